@@ hw/rtl/drsh_pkg.sv @@
// ============================================================================
// drsh_pkg
// Shared types, constants and modular arithmetic helpers for the double
// rolling substring hash block.
// ============================================================================
package drsh_pkg;

    // store geometry
    localparam int unsigned MAX_LEN   = 4096;
    localparam int unsigned ADDR_W    = 12;
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned HASH_W    = 30;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned NUM_LANES = 2;

    // hash constants
    localparam logic [HASH_W-1:0] BASE_FIRST  = 30'd31;
    localparam logic [HASH_W-1:0] MOD_FIRST   = 30'd1000000009;
    localparam logic [HASH_W-1:0] BASE_SECOND = 30'd103;
    localparam logic [HASH_W-1:0] MOD_SECOND  = 30'd1000000021;

    // multiplier bit counts: the base fits in seven bits, a power needs all
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned APPEND_STEPS = 7;
    localparam int unsigned QUERY_STEPS  = 30;

    // request actions
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clr;
        logic ld_append;
        logic rd_first;
        logic rd_second;
        logic ld_query;
        logic step;
        logic fin;
        logic wr_append;
        logic out_load;
        logic out_err;
        logic out_use_hash;
    } drsh_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty_range;
        logic past_end;
    } drsh_status_t;

    function automatic logic [HASH_W-1:0] lane_mod(input int unsigned lane);
        return (lane == 0) ? MOD_FIRST : MOD_SECOND;
    endfunction

    function automatic logic [HASH_W-1:0] lane_base(input int unsigned lane);
        return (lane == 0) ? BASE_FIRST : BASE_SECOND;
    endfunction

    // one msb-first step of interleaved modular multiplication:
    // (2*acc + bit_in*a) mod m, the sum stays below 3*m
    function automatic logic [HASH_W-1:0] mm_step(
        input logic [HASH_W-1:0] acc,
        input logic [HASH_W-1:0] a,
        input logic              bit_in,
        input logic [HASH_W-1:0] m
    );
        logic [HASH_W+1:0] t;
        logic [HASH_W+1:0] one_m;
        logic [HASH_W+1:0] two_m;
        logic [HASH_W+1:0] t1;
        logic [HASH_W+1:0] t2;
        t     = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, a} : '0);
        one_m = {2'b00, m};
        two_m = {1'b0, m, 1'b0};
        t1    = t - one_m;
        t2    = t - two_m;
        if (t >= two_m) begin
            return t2[HASH_W-1:0];
        end
        else if (t >= one_m) begin
            return t1[HASH_W-1:0];
        end
        else begin
            return t[HASH_W-1:0];
        end
    endfunction

    // closing step: (acc + c) mod m, or (c - acc) mod m when sub is set
    function automatic logic [HASH_W-1:0] mm_final(
        input logic [HASH_W-1:0] acc,
        input logic [HASH_W-1:0] c,
        input logic              sub,
        input logic [HASH_W-1:0] m
    );
        logic [HASH_W:0] s;
        logic [HASH_W:0] s_red;
        logic [HASH_W:0] d;
        logic [HASH_W:0] d_fix;
        s     = {1'b0, acc} + {1'b0, c};
        s_red = s - {1'b0, m};
        d     = {1'b0, c} - {1'b0, acc};
        d_fix = d + {1'b0, m};
        if (sub) begin
            return d[HASH_W] ? d_fix[HASH_W-1:0] : d[HASH_W-1:0];
        end
        else begin
            return (s >= {1'b0, m}) ? s_red[HASH_W-1:0] : s[HASH_W-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/drsh_if.sv @@
// ============================================================================
// drsh_if
// Valid/ready channels for requests into and results out of the hash block.
// ============================================================================
interface drsh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [11:0] range_start;
    logic [11:0] range_end;
    logic        which_hash;

    modport source (
        output valid, action, char_code, range_start, range_end, which_hash,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, range_start, range_end, which_hash,
        output ready
    );
endinterface

interface drsh_res_if;
    logic        valid;
    logic        ready;
    logic [29:0] hash_value;
    logic [12:0] string_length;
    logic        error_flag;

    modport source (
        output valid, hash_value, string_length, error_flag,
        input  ready
    );
    modport sink (
        input  valid, hash_value, string_length, error_flag,
        output ready
    );
endinterface

@@ hw/rtl/drsh_ram.sv @@
// ============================================================================
// drsh_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module drsh_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/drsh_datapath.sv @@
// ============================================================================
// drsh_datapath
// Prefix and power stores, two bit-serial modular multipliers per hash lane,
// request capture and the result register.
// ============================================================================
module drsh_datapath
    import drsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [ADDR_W-1:0]     range_start,
    input  logic [ADDR_W-1:0]     range_end,
    input  logic                  which_hash,
    input  drsh_cmd_t             cmd,
    output drsh_status_t          status,
    output logic [HASH_W-1:0]     hash_value,
    output logic [LEN_W-1:0]      string_length,
    output logic                  error_flag
);

    // captured request fields
    logic [ADDR_W-1:0] l_reg, l_next;
    logic [ADDR_W-1:0] r_reg, r_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              sel_reg, sel_next;

    // string state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [HASH_W-1:0] pow_cur_reg [NUM_LANES];
    logic [HASH_W-1:0] pow_cur_next [NUM_LANES];
    logic [HASH_W-1:0] last_prefix_reg [NUM_LANES];
    logic [HASH_W-1:0] last_prefix_next [NUM_LANES];

    // multiplier operands and accumulators
    logic [HASH_W-1:0] a_p_reg [NUM_LANES];
    logic [HASH_W-1:0] a_p_next [NUM_LANES];
    logic [HASH_W-1:0] a_w_reg [NUM_LANES];
    logic [HASH_W-1:0] a_w_next [NUM_LANES];
    logic [HASH_W-1:0] b_reg [NUM_LANES];
    logic [HASH_W-1:0] b_next [NUM_LANES];
    logic [HASH_W-1:0] c_reg [NUM_LANES];
    logic [HASH_W-1:0] c_next [NUM_LANES];
    logic [HASH_W-1:0] acc_p_reg [NUM_LANES];
    logic [HASH_W-1:0] acc_p_next [NUM_LANES];
    logic [HASH_W-1:0] acc_w_reg [NUM_LANES];
    logic [HASH_W-1:0] acc_w_next [NUM_LANES];
    logic              sub_reg, sub_next;

    // result register
    logic [HASH_W-1:0] out_hash_reg, out_hash_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_err_reg, out_err_next;

    // memory ports
    logic [HASH_W-1:0] prefix_rdata [NUM_LANES];
    logic [HASH_W-1:0] power_rdata [NUM_LANES];
    logic [ADDR_W-1:0] prefix_raddr;
    logic [ADDR_W-1:0] power_raddr;
    logic              prefix_re;

    assign prefix_re    = cmd.rd_first | cmd.rd_second;
    assign prefix_raddr = cmd.rd_first ? r_reg : (l_reg - ADDR_W'(1));
    assign power_raddr  = r_reg - l_reg;

    // power store entry k+1 lives at address k, entry zero is the constant one
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        drsh_ram #(
            .WIDTH (HASH_W),
            .DEPTH (MAX_LEN)
        ) u_prefix_ram (
            .clk   (clk),
            .we    (cmd.wr_append),
            .waddr (len_reg[ADDR_W-1:0]),
            .wdata (acc_p_reg[g]),
            .re    (prefix_re),
            .raddr (prefix_raddr),
            .rdata (prefix_rdata[g])
        );

        drsh_ram #(
            .WIDTH (HASH_W),
            .DEPTH (MAX_LEN)
        ) u_power_ram (
            .clk   (clk),
            .we    (cmd.wr_append),
            .waddr (len_reg[ADDR_W-1:0]),
            .wdata (acc_w_reg[g]),
            .re    (cmd.rd_first),
            .raddr (power_raddr),
            .rdata (power_rdata[g])
        );
    end

    // status toward the controller
    assign status.full        = (len_reg == LEN_W'(MAX_LEN));
    assign status.empty_range = (l_reg > r_reg);
    assign status.past_end    = ({1'b0, r_reg} >= len_reg);

    // next-state logic
    always_comb
    begin
        l_next        = l_reg;
        r_next        = r_reg;
        ch_next       = ch_reg;
        sel_next      = sel_reg;
        len_next      = len_reg;
        sub_next      = sub_reg;
        out_hash_next = out_hash_reg;
        out_len_next  = out_len_reg;
        out_err_next  = out_err_reg;

        // request capture
        if (cmd.capture)
        begin
            l_next   = range_start;
            r_next   = range_end;
            ch_next  = char_code;
            sel_next = which_hash;
        end

        // length bookkeeping
        if (cmd.clr)
        begin
            len_next = '0;
        end
        else if (cmd.wr_append)
        begin
            len_next = len_reg + LEN_W'(1);
        end

        if (cmd.ld_append)
        begin
            sub_next = 1'b0;
        end
        else if (cmd.ld_query)
        begin
            sub_next = 1'b1;
        end

        for (int k = 0; k < NUM_LANES; k++)
        begin
            pow_cur_next[k]     = pow_cur_reg[k];
            last_prefix_next[k] = last_prefix_reg[k];
            a_p_next[k]         = a_p_reg[k];
            a_w_next[k]         = a_w_reg[k];
            b_next[k]           = b_reg[k];
            c_next[k]           = c_reg[k];
            acc_p_next[k]       = acc_p_reg[k];
            acc_w_next[k]       = acc_w_reg[k];

            // after a clear the next power to extend from is base^0
            if (cmd.clr)
            begin
                pow_cur_next[k] = HASH_W'(1);
            end

            // append: prefix*base + byte and power*base, base bits msb first
            if (cmd.ld_append)
            begin
                a_p_next[k]   = (len_reg == '0) ? '0 : last_prefix_reg[k];
                a_w_next[k]   = pow_cur_reg[k];
                b_next[k]     = lane_base(k) << (HASH_W - APPEND_STEPS);
                c_next[k]     = {{(HASH_W-CHAR_W){1'b0}}, ch_reg};
                acc_p_next[k] = '0;
                acc_w_next[k] = '0;
            end

            // query: whole prefix and power arrive from the first read
            if (cmd.rd_second)
            begin
                c_next[k] = prefix_rdata[k];
                b_next[k] = power_rdata[k];
            end

            // query: lower prefix arrives from the second read
            if (cmd.ld_query)
            begin
                a_p_next[k]   = (l_reg == '0) ? '0 : prefix_rdata[k];
                acc_p_next[k] = '0;
            end

            // one multiplier bit per cycle
            if (cmd.step)
            begin
                acc_p_next[k] = mm_step(acc_p_reg[k], a_p_reg[k], b_reg[k][HASH_W-1],
                                        lane_mod(k));
                acc_w_next[k] = mm_step(acc_w_reg[k], a_w_reg[k], b_reg[k][HASH_W-1],
                                        lane_mod(k));
                b_next[k]     = b_reg[k] << 1;
            end

            // add the byte, or subtract the cut from the whole prefix
            if (cmd.fin)
            begin
                acc_p_next[k] = mm_final(acc_p_reg[k], c_reg[k], sub_reg, lane_mod(k));
            end

            if (cmd.wr_append)
            begin
                last_prefix_next[k] = acc_p_reg[k];
                pow_cur_next[k]     = acc_w_reg[k];
            end
        end

        // result register
        if (cmd.out_load)
        begin
            out_hash_next = cmd.out_use_hash ? acc_p_reg[sel_reg] : '0;
            out_len_next  = len_reg;
            out_err_next  = cmd.out_err;
        end
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                pow_cur_reg[k] <= HASH_W'(1);
            end
        end
        else
        begin
            len_reg <= len_next;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                pow_cur_reg[k] <= pow_cur_next[k];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        l_reg        <= l_next;
        r_reg        <= r_next;
        ch_reg       <= ch_next;
        sel_reg      <= sel_next;
        sub_reg      <= sub_next;
        out_hash_reg <= out_hash_next;
        out_len_reg  <= out_len_next;
        out_err_reg  <= out_err_next;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            last_prefix_reg[k] <= last_prefix_next[k];
            a_p_reg[k]         <= a_p_next[k];
            a_w_reg[k]         <= a_w_next[k];
            b_reg[k]           <= b_next[k];
            c_reg[k]           <= c_next[k];
            acc_p_reg[k]       <= acc_p_next[k];
            acc_w_reg[k]       <= acc_w_next[k];
        end
    end

    assign hash_value    = out_hash_reg;
    assign string_length = out_len_reg;
    assign error_flag    = out_err_reg;

endmodule

@@ hw/rtl/drsh_ctrl.sv @@
// ============================================================================
// drsh_ctrl
// Sequencer for clear, append and query requests and the result handshake.
// ============================================================================
module drsh_ctrl
    import drsh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  action_t      req_action,
    output logic         res_valid,
    input  logic         res_ready,
    output drsh_cmd_t    cmd,
    input  drsh_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_LOW,
        S_LOAD_QUERY,
        S_STEP,
        S_FINAL,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    action_t          action_reg, action_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic             use_hash_reg, use_hash_next;
    logic             out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        action_next   = action_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        use_hash_next = use_hash_reg;
        out_valid_next = out_valid_reg & ~res_ready;
        cmd           = '0;
        cmd.out_err      = err_reg;
        cmd.out_use_hash = use_hash_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture   = 1'b1;
                    action_next   = req_action;
                    err_next      = 1'b0;
                    use_hash_next = 1'b0;
                    state_next    = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (action_reg)
                    ACT_CLEAR:
                    begin
                        cmd.clr    = 1'b1;
                        state_next = S_FINISH;
                    end
                    ACT_APPEND:
                    begin
                        if (status.full)
                        begin
                            err_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.ld_append = 1'b1;
                            cnt_next      = CNT_W'(APPEND_STEPS);
                            state_next    = S_STEP;
                        end
                    end
                    ACT_QUERY:
                    begin
                        priority if (status.empty_range)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (status.past_end)
                        begin
                            err_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_READ_LOW;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // upper prefix and power data come back, lower prefix read goes out
            S_READ_LOW:
            begin
                cmd.rd_second = 1'b1;
                state_next    = S_LOAD_QUERY;
            end

            S_LOAD_QUERY:
            begin
                cmd.ld_query = 1'b1;
                cnt_next     = CNT_W'(QUERY_STEPS);
                state_next   = S_STEP;
            end

            S_STEP:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                cmd.fin = 1'b1;
                if (action_reg == ACT_APPEND)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    use_hash_next = 1'b1;
                    state_next    = S_FINISH;
                end
            end

            S_WRITE:
            begin
                cmd.wr_append = 1'b1;
                state_next    = S_FINISH;
            end

            // wait for a free result slot
            S_FINISH:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            action_reg    <= ACT_CLEAR;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            use_hash_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            action_reg    <= action_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            use_hash_reg  <= use_hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/double_rolling_substring_hash.sv @@
// ============================================================================
// double_rolling_substring_hash
// Byte string store with prefix hashes under two polynomial rolling hashes.
// ============================================================================
// Holds up to 4096 bytes with their prefix hashes (base 31 mod 1000000009 and
// base 103 mod 1000000021) and power tables, and answers one request at a time
// with one result. Both hashes are built by bit-serial modular multipliers
// that take one multiplier bit per cycle. From accept to result, a clear or a
// rejected request passes the dispatch and finish states, an append also a
// 7-bit base multiply, the byte add and the store write, and a query also the
// two prefix reads, a 30-bit power multiply and the subtract. The block is
// ready for a new request as soon as the previous result is registered, even
// while that result still waits on the result channel. The stores need no
// clearing after reset: reads only reach entries written since.
module double_rolling_substring_hash
    import drsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    drsh_req_if.sink   request,
    drsh_res_if.source result
);

    drsh_cmd_t    cmd;
    drsh_status_t status;
    logic         res_valid;

    // sequencer
    drsh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_ready  (request.ready),
        .req_action (action_t'(request.action)),
        .res_valid  (res_valid),
        .res_ready  (result.ready),
        .cmd        (cmd),
        .status     (status)
    );

    // stores and arithmetic
    drsh_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_code     (request.char_code),
        .range_start   (request.range_start),
        .range_end     (request.range_end),
        .which_hash    (request.which_hash),
        .cmd           (cmd),
        .status        (status),
        .hash_value    (result.hash_value),
        .string_length (result.string_length),
        .error_flag    (result.error_flag)
    );

    assign result.valid = res_valid;

endmodule

@@ bench/double_rolling_substring_hash_test.sv @@
// ============================================================================
// double_rolling_substring_hash_test
// Self-checking bench for the double rolling substring hash block. A short
// stimulus table covers the field extremes, the empty range, queries past the
// end, the unused action and clears. Random requests follow, with a pass that
// builds a long string and queries long spans of it. Results are compared in
// order with fixed values or a local model of both hash lanes. The request
// side sends bursts with gaps; the result side stalls in changing patterns.
// ============================================================================
module double_rolling_substring_hash_test;
    import drsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // action code that the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // length of the string built by the long-string pass
    localparam int unsigned FILL_LEN = 600;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [11:0] range_start;
        logic [11:0] range_end;
        logic        which_hash;
    } hash_req_t;

    typedef struct packed {
        logic [29:0] hash_value;
        logic [12:0] string_length;
        logic        error_flag;
    } hash_res_t;

    typedef struct packed {
        hash_req_t req;
        logic      fixed;
        hash_res_t res;
    } smoke_row_t;

    logic clk;
    logic rst_n;

    drsh_req_if request_bus();
    drsh_res_if result_bus();

    double_rolling_substring_hash u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .result  (result_bus)
    );

    // local copy of the string tables, one row per hash lane
    logic [29:0] prefix_tab [0:1][0:MAX_LEN-1];
    logic [29:0] power_tab  [0:1][0:MAX_LEN];
    int unsigned text_len;

    hash_res_t   pending_hashes[$];
    smoke_row_t  smoke_rows[$];
    int unsigned mismatch_count;
    int unsigned burst_left;
    int unsigned stall_mode;
    int unsigned stall_left;
    int unsigned stall_tick;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("double_rolling_substring_hash_test failed");
        $finish;
    end

    // model of the block: applies one request and returns its result
    function automatic hash_res_t apply_request(hash_req_t q);
        hash_res_t       o;
        int unsigned     pos;
        int unsigned     lane;
        longint unsigned m;
        longint unsigned b;
        longint unsigned whole;
        longint unsigned cut;
        o = '0;
        case (q.action)
            ACT_CLEAR:
            begin
                text_len = 0;
            end
            ACT_APPEND:
            begin
                if (text_len >= MAX_LEN)
                begin
                    o.error_flag = 1'b1;
                end
                else
                begin
                    pos = text_len;
                    for (lane = 0; lane < 2; lane++)
                    begin
                        m = (lane == 0) ? 64'(MOD_FIRST) : 64'(MOD_SECOND);
                        b = (lane == 0) ? 64'(BASE_FIRST) : 64'(BASE_SECOND);
                        if (pos == 0)
                        begin
                            prefix_tab[lane][0] = 30'(q.char_code);
                        end
                        else
                        begin
                            prefix_tab[lane][pos] =
                                30'((64'(prefix_tab[lane][pos-1]) * b
                                     + 64'(q.char_code)) % m);
                        end
                        power_tab[lane][pos+1] = 30'((64'(power_tab[lane][pos]) * b) % m);
                    end
                    text_len = pos + 1;
                end
            end
            ACT_QUERY:
            begin
                if (q.range_start <= q.range_end)
                begin
                    if (q.range_end >= text_len)
                    begin
                        o.error_flag = 1'b1;
                    end
                    else
                    begin
                        lane  = 32'(q.which_hash);
                        m     = (lane == 0) ? 64'(MOD_FIRST) : 64'(MOD_SECOND);
                        whole = 64'(prefix_tab[lane][q.range_end]);
                        if (q.range_start == 0)
                        begin
                            o.hash_value = 30'(whole);
                        end
                        else
                        begin
                            cut = (64'(prefix_tab[lane][q.range_start-1])
                                * 64'(power_tab[lane][q.range_end-q.range_start+1])) % m;
                            o.hash_value = 30'((whole + m - cut) % m);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.string_length = 13'(text_len);
        return o;
    endfunction

    function automatic smoke_row_t mk_row(logic [1:0] act, logic [7:0] ch,
                                          logic [11:0] first, logic [11:0] last,
                                          logic sel, logic fixed, logic [29:0] h,
                                          logic [12:0] len, logic err);
        smoke_row_t r;
        r.req   = '{act, ch, first, last, sel};
        r.fixed = fixed;
        r.res   = '{h, len, err};
        return r;
    endfunction

    // random request: half are queries, most of them inside the stored string
    function automatic hash_req_t random_request();
        hash_req_t   q;
        int unsigned pick;
        q.char_code   = 8'($urandom_range(0, 255));
        q.range_start = 12'($urandom);
        q.range_end   = 12'($urandom);
        q.which_hash  = 1'($urandom_range(0, 1));
        pick          = $urandom_range(0, 99);
        if (pick < 2)
        begin
            q.action = ACT_CLEAR;
        end
        else if (pick < 4)
        begin
            q.action = ACT_UNUSED;
        end
        else if (pick < 50)
        begin
            q.action = ACT_APPEND;
        end
        else
        begin
            q.action = ACT_QUERY;
            if (pick < 88 && text_len > 0)
            begin
                q.range_end = 12'($urandom_range(0, text_len - 1));
                case ($urandom_range(0, 3))
                    0: q.range_start = 12'd0;
                    1: q.range_start = q.range_end;
                    default: q.range_start = 12'($urandom_range(0, q.range_end));
                endcase
            end
            else if (pick < 94)
            begin
                q.range_start = 12'($urandom_range(1, MAX_LEN - 1));
                q.range_end   = 12'($urandom_range(0, q.range_start - 1));
            end
        end
        return q;
    endfunction

    // sender spacing: bursts of back-to-back requests, then a gap
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 24);
        gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // present one request, wait for its handshake, queue its expected result
    task automatic send_request(hash_req_t q, logic fixed, hash_res_t fixed_res);
        hash_res_t predicted;
        request_bus.valid       <= 1'b1;
        request_bus.action      <= q.action;
        request_bus.char_code   <= q.char_code;
        request_bus.range_start <= q.range_start;
        request_bus.range_end   <= q.range_end;
        request_bus.which_hash  <= q.which_hash;
        do
        begin
            @(posedge clk);
        end
        while (!request_bus.ready);
        predicted = apply_request(q);
        pending_hashes.push_back(fixed ? fixed_res : predicted);
        pace();
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        request_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_hashes.size() != 0);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
        begin
            send_request(random_request(), 1'b0, '0);
            if ($urandom_range(0, 149) == 0)
            begin
                drain();
            end
        end
    endtask

    // build a long string from scratch, then query long spans of it
    task automatic run_fill();
        hash_req_t   q;
        int unsigned n;
        q = '{ACT_CLEAR, 8'd0, 12'd0, 12'd0, 1'b0};
        send_request(q, 1'b0, '0);
        for (n = 0; n < FILL_LEN; n++)
        begin
            q = '{ACT_APPEND, 8'($urandom_range(0, 255)), 12'($urandom), 12'($urandom),
                  1'($urandom_range(0, 1))};
            send_request(q, 1'b0, '0);
        end
        q = '{ACT_QUERY, 8'd0, 12'd0, 12'(FILL_LEN - 1), 1'b0};
        send_request(q, 1'b0, '0);
        q.which_hash = 1'b1;
        send_request(q, 1'b0, '0);
        q.range_start = 12'(FILL_LEN - 1);
        send_request(q, 1'b0, '0);
        for (n = 0; n < 40; n++)
        begin
            q.range_end   = 12'($urandom_range(0, FILL_LEN - 1));
            q.range_start = ($urandom_range(0, 2) == 0) ? 12'd0
                                                        : 12'($urandom_range(0, q.range_end));
            q.which_hash  = 1'($urandom_range(0, 1));
            send_request(q, 1'b0, '0);
        end
    endtask

    // result side: ready follows a stall mode, picked anew at random when its run ends
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: result_bus.ready <= 1'b1;
            1: result_bus.ready <= ($urandom_range(0, 1) == 1);
            2: result_bus.ready <= (stall_tick[1:0] == 2'd0);
            default: result_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        hash_res_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hash %0d len %0d err %0b",
                         $time, result_bus.hash_value, result_bus.string_length,
                         result_bus.error_flag);
                mismatch_count++;
            end
            else
            begin
                want = pending_hashes.pop_front();
                check_field("hash_value", 32'(want.hash_value),
                            32'(result_bus.hash_value));
                check_field("string_length", 32'(want.string_length),
                            32'(result_bus.string_length));
                check_field("error_flag", 32'(want.error_flag),
                            32'(result_bus.error_flag));
            end
        end
    end

    // main sequence
    initial
    begin
        int unsigned lane;
        int unsigned idx;
        rst_n                   = 1'b0;
        request_bus.valid       = 1'b0;
        request_bus.action      = ACT_CLEAR;
        request_bus.char_code   = 8'd0;
        request_bus.range_start = 12'd0;
        request_bus.range_end   = 12'd0;
        request_bus.which_hash  = 1'b0;
        result_bus.ready        = 1'b0;
        mismatch_count          = 0;
        burst_left              = 0;
        stall_mode              = 0;
        stall_left              = 0;
        stall_tick              = 0;
        text_len                = 0;
        for (lane = 0; lane < 2; lane++)
        begin
            for (idx = 0; idx <= MAX_LEN; idx++)
            begin
                power_tab[lane][idx] = 30'd0;
                if (idx < MAX_LEN)
                begin
                    prefix_tab[lane][idx] = 30'd0;
                end
            end
            power_tab[lane][0] = 30'd1;
        end

        // stimulus table
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd0,    1'b0, 1, 0, 0, 1));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd4095, 12'd0,    1'b1, 1, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_UNUSED, 8'hFF, 12'd4095, 12'd4095, 1'b1, 1, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_CLEAR,  8'h00, 12'd0,    12'd0,    1'b0, 1, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_APPEND, 8'h00, 12'd0,    12'd0,    1'b0, 1, 0, 1, 0));
        smoke_rows.push_back(mk_row(ACT_APPEND, 8'hFF, 12'd4095, 12'd4095, 1'b1, 1, 0, 2, 0));
        smoke_rows.push_back(mk_row(ACT_APPEND, 8'h80, 12'd0,    12'd0,    1'b0, 1, 0, 3, 0));
        smoke_rows.push_back(mk_row(ACT_APPEND, 8'h7F, 12'd0,    12'd0,    1'b0, 1, 0, 4, 0));
        smoke_rows.push_back(mk_row(ACT_APPEND, 8'h01, 12'd0,    12'd0,    1'b0, 1, 0, 5, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd0,    1'b0, 1, 0, 5, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd1,    12'd1,    1'b0, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd4,    1'b0, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd4,    1'b1, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd1,    12'd4,    1'b0, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd1,    12'd4,    1'b1, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd4,    12'd4,    1'b1, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd3,    12'd2,    1'b0, 1, 0, 5, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd5,    1'b0, 1, 0, 5, 1));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd4095, 12'd4095, 1'b1, 1, 0, 5, 1));
        smoke_rows.push_back(mk_row(ACT_UNUSED, 8'h00, 12'd0,    12'd0,    1'b0, 1, 0, 5, 0));
        smoke_rows.push_back(mk_row(ACT_CLEAR,  8'hFF, 12'd4095, 12'd4095, 1'b1, 1, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, 1, 0, 0, 1));
        smoke_rows.push_back(mk_row(ACT_APPEND, 8'hAA, 12'd0,    12'd0,    1'b0, 1, 0, 1, 0));
        smoke_rows.push_back(mk_row(ACT_QUERY,  8'h00, 12'd0,    12'd0,    1'b1, 0, 0, 0, 0));
        smoke_rows.push_back(mk_row(ACT_CLEAR,  8'h00, 12'd0,    12'd0,    1'b0, 1, 0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (smoke_rows[i])
        begin
            send_request(smoke_rows[i].req, smoke_rows[i].fixed, smoke_rows[i].res);
        end
        drain();

        run_random(600);
        drain();
        run_fill();
        run_random(600);
        request_bus.valid <= 1'b0;

        // let the last results come back, then a short quiet tail
        while (pending_hashes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("double_rolling_substring_hash_test passed");
        end
        else
        begin
            $display("double_rolling_substring_hash_test failed");
        end
        $finish;
    end

endmodule
